// ----- hdl/permutation_unrank_macros.svh -----
`ifndef PERMUTATION_UNRANK_MACROS_SVH
`define PERMUTATION_UNRANK_MACROS_SVH

// same-cycle implication
`define PU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pu_pkg.sv -----
`timescale 1ns / 1ps
package pu_pkg;

    localparam int MAX_LENGTH = 20;
    localparam int RANK_W     = 62;
    localparam int VAL_W      = 5;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam logic [VAL_W-1:0] LEN_RESET = VAL_W'(4);

    typedef struct packed {
        logic             load;       // clamp rank, load first factorial
        logic             sub;        // remainder -= factorial
        logic             load_fact;  // load factorial for next position
        logic [VAL_W-1:0] fidx;       // factorial index to load
        logic [VAL_W-1:0] len;        // effective length, for the clamp
    } t_dp_ctrl;

    typedef struct packed {
        logic ge;                     // remainder >= factorial
    } t_dp_stat;

    function automatic logic [RANK_W-1:0] fact(input logic [VAL_W-1:0] idx);
        logic [RANK_W-1:0] f;
        case (idx)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = 62'd1;
        endcase
        return f;
    endfunction

endpackage

// ----- hdl/pu_datapath.sv -----
`timescale 1ns / 1ps
module pu_datapath (
    input  logic                      i_clk,
    input  logic [pu_pkg::RANK_W-1:0] i_rank,
    input  pu_pkg::t_dp_ctrl          i_ctrl,
    output pu_pkg::t_dp_stat          o_stat
);
    import pu_pkg::*;

    logic [RANK_W-1:0] r_rem;
    logic [RANK_W-1:0] r_fact;
    logic [RANK_W-1:0] n_rem;
    logic [RANK_W-1:0] n_fact;
    logic [RANK_W-1:0] w_top;

    assign w_top      = fact(i_ctrl.len);
    assign o_stat.ge  = (r_rem >= r_fact);

    always_comb begin
        n_rem  = r_rem;
        n_fact = r_fact;
        if (i_ctrl.load) begin
            // zero-based rank, clamped to 0..n!-1
            if (i_rank == '0) begin
                n_rem = '0;
            end else if (i_rank > w_top) begin
                n_rem = w_top - RANK_W'(1);
            end else begin
                n_rem = i_rank - RANK_W'(1);
            end
            n_fact = fact(i_ctrl.fidx);
        end else begin
            if (i_ctrl.sub) begin
                n_rem = r_rem - r_fact;
            end
            if (i_ctrl.load_fact) begin
                n_fact = fact(i_ctrl.fidx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_fact <= n_fact;
    end

endmodule

// ----- hdl/permutation_unrank.sv -----
// Lexicographic permutation unranking. Pulse i_start with a one-based i_rank
// while o_busy is low; ranks of zero read as one and ranks above n! as n!.
// The block then emits n results, one per position in order, each on
// o_element/o_position for a single cycle with o_valid high and o_last on the
// final one; the receiver cannot stall, so every strobe must be taken. One
// shared 62-bit compare/subtract unit walks the candidate values of each
// position one per cycle, either skipping a used value or subtracting the
// factorial once. n comes from the length register, written over the cfg
// channel; the user must write it only while idle, as the block itself does
// not enforce this; 0 reads as 1 and values above 20 as 20.
`timescale 1ns / 1ps
`include "permutation_unrank_macros.svh"
module permutation_unrank (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [pu_pkg::RANK_W-1:0] i_rank,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [pu_pkg::VAL_W-1:0]  i_cfg_data,
    output logic                      o_valid,
    output logic [pu_pkg::VAL_W-1:0]  o_element,
    output logic [pu_pkg::VAL_W-1:0]  o_position,
    output logic                      o_last
);
    import pu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [VAL_W-1:0]      r_len;
    logic [MAX_LENGTH-1:0] r_used, n_used;
    logic [IDX_W-1:0]      r_v, n_v;
    logic [VAL_W-1:0]      r_pos, n_pos;
    logic [VAL_W-1:0]      r_fidx, n_fidx;
    logic [VAL_W-1:0]      r_n, n_n;
    logic                  r_valid, n_valid;
    logic [VAL_W-1:0]      r_element, n_element;
    logic [VAL_W-1:0]      r_position, n_position;
    logic                  r_last, n_last;
    logic [VAL_W-1:0]      w_len;
    logic                  w_accept;
    t_dp_ctrl              w_ctrl;
    t_dp_stat              w_stat;

    assign w_len = (r_len == '0) ? VAL_W'(1) :
                   (r_len > VAL_W'(MAX_LENGTH)) ? VAL_W'(MAX_LENGTH) : r_len;
    assign w_accept    = i_start && (r_state == ST_IDLE);
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_element   = r_element;
    assign o_position  = r_position;
    assign o_last      = r_last;

    pu_datapath u_dp (
        .i_clk  (i_clk),
        .i_rank (i_rank),
        .i_ctrl (w_ctrl),
        .o_stat (w_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_v        = r_v;
        n_pos      = r_pos;
        n_fidx     = r_fidx;
        n_n        = r_n;
        n_valid    = 1'b0;
        n_element  = r_element;
        n_position = r_position;
        n_last     = r_last;
        w_ctrl     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    w_ctrl.load = 1'b1;
                    w_ctrl.fidx = w_len - VAL_W'(1);
                    w_ctrl.len  = w_len;
                    n_fidx      = w_len - VAL_W'(1);
                    n_n         = w_len;
                    n_used      = '0;
                    n_v         = '0;
                    n_pos       = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_used[r_v]) begin
                    n_v = r_v + IDX_W'(1);
                end else if (w_stat.ge) begin
                    w_ctrl.sub = 1'b1;
                    n_v        = r_v + IDX_W'(1);
                end else begin
                    n_valid          = 1'b1;
                    n_element        = VAL_W'(r_v) + VAL_W'(1);
                    n_position       = r_pos;
                    n_last           = (r_fidx == '0);
                    n_used[r_v]      = 1'b1;
                    n_v              = '0;
                    n_pos            = r_pos + VAL_W'(1);
                    n_fidx           = r_fidx - VAL_W'(1);
                    w_ctrl.load_fact = 1'b1;
                    w_ctrl.fidx      = r_fidx - VAL_W'(1);
                    if (r_fidx == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= LEN_RESET;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_used     <= n_used;
        r_v        <= n_v;
        r_pos      <= n_pos;
        r_fidx     <= n_fidx;
        r_n        <= n_n;
        r_element  <= n_element;
        r_position <= n_position;
        r_last     <= n_last;
    end

    `PU_ASSERT_NXT(a_start_clears, w_accept, (r_used == '0) && (r_pos == '0), "start did not clear")
    `PU_ASSERT_NOW(a_scan_range, r_state == ST_SCAN, VAL_W'(r_v) < r_n, "scan ran past length")
    `PU_ASSERT_NOW(a_last_idle, o_valid && o_last, r_state == ST_IDLE, "busy after last transfer")
    `PU_ASSERT_NOW(a_mid_busy, o_valid && !o_last, o_busy, "idle before last transfer")
    `PU_ASSERT_NOW(a_last_pos, o_valid && o_last, o_position == r_n - VAL_W'(1), "last at wrong position")

endmodule
